[rtl/jms_pkg.sv]
// jms_pkg: shared types, marker codes and the marker classifier for the
// jpeg marker segmenter. No dependencies; imported by every rtl file.
package jms_pkg;

	// default position counter width and output queue depth
	localparam int POS_WIDTH_DEF = 32;
	localparam int OUT_DEPTH     = 4;

	// marker byte values
	localparam logic [7:0] CODE_PREFIX = 8'hFF;
	localparam logic [7:0] CODE_STUFF  = 8'h00;
	localparam logic [7:0] CODE_TEM    = 8'h01;
	localparam logic [7:0] CODE_RES    = 8'h02;
	localparam logic [7:0] CODE_RES_HI = 8'hBF;
	localparam logic [7:0] CODE_SOF    = 8'hC0;
	localparam logic [7:0] CODE_DHT    = 8'hC4;
	localparam logic [7:0] CODE_JPG0   = 8'hC8;
	localparam logic [7:0] CODE_DAC    = 8'hCC;
	localparam logic [7:0] CODE_SOF_HI = 8'hCF;
	localparam logic [7:0] CODE_RST    = 8'hD0;
	localparam logic [7:0] CODE_RST_HI = 8'hD7;
	localparam logic [7:0] CODE_SOI    = 8'hD8;
	localparam logic [7:0] CODE_EOI    = 8'hD9;
	localparam logic [7:0] CODE_SOS    = 8'hDA;
	localparam logic [7:0] CODE_EXP    = 8'hDF;
	localparam logic [7:0] CODE_APP    = 8'hE0;
	localparam logic [7:0] CODE_APP_HI = 8'hEF;
	localparam logic [7:0] CODE_JPG    = 8'hF0;
	localparam logic [7:0] CODE_JPG_HI = 8'hFD;

	// segment kinds as reported on seg_kind
	typedef enum logic [4:0] {
		K_SOF = 5'd0,  K_DHT = 5'd1,  K_DAC = 5'd2,  K_RST = 5'd3,
		K_SOI = 5'd4,  K_EOI = 5'd5,  K_SOS = 5'd6,  K_DQT = 5'd7,
		K_DNL = 5'd8,  K_DRI = 5'd9,  K_DHP = 5'd10, K_EXP = 5'd11,
		K_APP = 5'd12, K_JPG = 5'd13, K_COM = 5'd14, K_TEM = 5'd15,
		K_RES = 5'd16, K_IMG = 5'd17, K_UNK = 5'd18
	} seg_kind_t;

	// one finished segment as queued for the output channel
	typedef struct packed {
		seg_kind_t   kind;
		logic [7:0]  sub;
		logic [7:0]  code;
		logic [31:0] offset;
		logic [31:0] size;
		logic        trunc;
		logic        last;
	} seg_res_t;

	// classifier answer for one marker code
	typedef struct packed {
		seg_kind_t  kind;
		logic [7:0] sub;
		logic       alone;
	} mk_class_t;

	// classify a marker code in 0x01..0xFE by range
	function automatic mk_class_t mk_classify(logic [7:0] c);
		mk_class_t r;
		r.sub   = 8'h00;
		r.alone = 1'b0;
		r.kind  = K_COM;
		if (c == CODE_TEM) begin
			r.kind  = K_TEM;
			r.alone = 1'b1;
		end else if (c <= CODE_RES_HI) begin
			r.kind = K_RES;
			r.sub  = c - CODE_RES;
		end else if (c <= CODE_SOF_HI) begin
			if (c == CODE_DHT) r.kind = K_DHT;
			else if (c == CODE_JPG0) r.kind = K_JPG;
			else if (c == CODE_DAC) r.kind = K_DAC;
			else begin
				r.kind = K_SOF;
				r.sub  = c - CODE_SOF;
			end
		end else if (c <= CODE_RST_HI) begin
			r.kind  = K_RST;
			r.sub   = c - CODE_RST;
			r.alone = 1'b1;
		end else if (c == CODE_SOI) begin
			r.kind  = K_SOI;
			r.alone = 1'b1;
		end else if (c == CODE_EOI) begin
			r.kind  = K_EOI;
			r.alone = 1'b1;
		end else if (c <= CODE_EXP) begin
			// SOS, DQT, DNL, DRI, DHP, EXP are consecutive codes and kinds
			r.kind = seg_kind_t'(5'(K_SOS) + 5'(c - CODE_SOS));
		end else if (c <= CODE_APP_HI) begin
			r.kind = K_APP;
			r.sub  = c - CODE_APP;
		end else if (c <= CODE_JPG_HI) begin
			r.kind = K_JPG;
			r.sub  = c - CODE_JPG;
		end
		return r;
	endfunction

endpackage

[rtl/jms_out_fifo.sv]
// jms_out_fifo: small result queue between the segmenter core and the
// output channel; takes up to two results a cycle, gives one. Uses jms_pkg.
module jms_out_fifo
	import jms_pkg::*;
#(
	parameter int DEPTH = OUT_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_cnt,
	input  seg_res_t   push0,
	input  seg_res_t   push1,
	output logic       room2,
	output logic       pop_valid,
	input  logic       pop_ready,
	output seg_res_t   pop_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	seg_res_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            pop;

	assign pop       = pop_valid & pop_ready;
	assign pop_valid = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];
	assign room2     = (cnt_q <= CW'(DEPTH - 2));

	// storage, first result at the write pointer, second right after it
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) mem_q[wr_q] <= push0;
		if (push_cnt == 2'd2) mem_q[wr_q + PW'(1)] <= push1;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PW'(push_cnt);
			if (pop) rd_q <= rd_q + PW'(1);
			cnt_q <= cnt_q + CW'(push_cnt) - CW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt != 2'd0) |-> room2)
		else $error("result pushed without room");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
	a_head_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && !pop_ready) |=> (pop_valid && $stable(pop_data)))
		else $error("waiting head beat changed");
`endif

endmodule

[rtl/jpeg_marker_segmenter.sv]
// jpeg_marker_segmenter: splits a jpeg byte stream into marker segments.
// Uses jms_pkg (types, classifier) and jms_out_fifo (result queue).
//
//   channel | signals                              | beat
//   in      | in_valid in_ready                    | data_byte, end_of_stream
//   out     | out_valid out_ready                  | seg_kind seg_sub marker_code
//           |                                      | seg_offset seg_size truncated
//           |                                      | last_result
//
// One byte is taken per cycle; its results are computed in the same cycle
// from the stream state registers and land in a four-entry result queue.
// A byte may cause up to two results; in_ready drops only while the queue
// lacks room for two, so the output side sets the rate when it stalls.
// Reset (or a beat with end_of_stream) returns to the start of a stream
// at offset zero; there is no clearing pass.
module jpeg_marker_segmenter
	import jms_pkg::*;
#(
	parameter int POS_WIDTH = POS_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  seg_kind,
	output logic [7:0]  seg_sub,
	output logic [7:0]  marker_code,
	output logic [31:0] seg_offset,
	output logic [31:0] seg_size,
	output logic        truncated,
	output logic        last_result
);

	localparam int PW1 = POS_WIDTH + 1;
	localparam int SW  = (PW1 > 32) ? PW1 : 32;
	localparam int OW  = (POS_WIDTH > 32) ? POS_WIDTH : 32;
	localparam logic [15:0] LEN_SELF = 16'd2;

	typedef enum logic [5:0] {
		PH_PREFIX = 6'b000001,
		PH_CODE   = 6'b000010,
		PH_LEN_HI = 6'b000100,
		PH_LEN_LO = 6'b001000,
		PH_BODY   = 6'b010000,
		PH_SCAN   = 6'b100000
	} phase_t;

	phase_t                 phase_q, nx_phase;
	logic [POS_WIDTH-1:0]   pos_q, nx_pos;
	seg_kind_t              kind_q, nx_kind;
	logic [7:0]             code_q, nx_code;
	logic [7:0]             sub_q, nx_sub;
	logic [POS_WIDTH-1:0]   start_q, nx_start;
	logic [15:0]            len_q, nx_len;
	logic                   saw_q, nx_saw;
	logic                   sos_q, nx_sos;

	logic                   accept;
	logic                   room2;
	mk_class_t              cls;
	logic [POS_WIDTH:0]     pos_inc;
	logic [POS_WIDTH-1:0]   ff_pos;
	logic [15:0]            len_full;
	logic                   do_open, do_finish;
	logic                   va, vb, vc;
	seg_res_t               res_a, res_b, res_c, slot0, slot1, head;
	logic [1:0]             n_res, push_cnt;

	// size of a segment from its start to an exclusive end, clamped both ways
	function automatic logic [31:0] seg_len(logic [POS_WIDTH:0] e,
	                                        logic [POS_WIDTH-1:0] s);
		logic [POS_WIDTH+1:0] d;
		logic [SW-1:0]        dx;
		d  = {1'b0, e} - {2'b00, s};
		dx = SW'(d[POS_WIDTH:0]);
		if (d[POS_WIDTH+1]) return 32'd0;
		if (dx > SW'(32'hFFFF_FFFF)) return 32'hFFFF_FFFF;
		return dx[31:0];
	endfunction

	function automatic seg_res_t make_res(seg_kind_t k, logic [7:0] sb,
	                                      logic [7:0] cd, logic [POS_WIDTH-1:0] s,
	                                      logic [POS_WIDTH:0] e, logic tr);
		seg_res_t      r;
		logic [OW-1:0] so;
		so       = OW'(s);
		r.kind   = k;
		r.sub    = sb;
		r.code   = cd;
		r.offset = so[31:0];
		r.size   = seg_len(e, s);
		r.trunc  = tr;
		r.last   = 1'b0;
		return r;
	endfunction

	assign accept   = in_valid & in_ready;
	assign in_ready = room2;
	assign cls      = mk_classify(data_byte);
	assign pos_inc  = {1'b0, pos_q} + PW1'(1);
	assign ff_pos   = (pos_q == '0) ? '0 : pos_q - POS_WIDTH'(1);
	assign len_full = len_q | {8'h00, data_byte};

	// next stream state and the results this byte causes
	always_comb begin
		nx_phase  = phase_q;
		nx_pos    = (pos_q == '1) ? pos_q : pos_q + POS_WIDTH'(1);
		nx_kind   = kind_q;
		nx_code   = code_q;
		nx_sub    = sub_q;
		nx_start  = start_q;
		nx_len    = len_q;
		nx_saw    = saw_q;
		nx_sos    = sos_q;
		do_open   = 1'b0;
		do_finish = 1'b0;
		va        = 1'b0;
		vb        = 1'b0;
		vc        = 1'b0;

		case (phase_q)
			PH_PREFIX: begin
				nx_start = pos_q;
				nx_kind  = sos_q ? K_IMG : K_UNK;
				nx_code  = 8'h00;
				nx_sub   = 8'h00;
				if (data_byte == CODE_PREFIX) begin
					nx_phase = PH_CODE;
				end else begin
					nx_sos   = 1'b0;
					nx_saw   = 1'b0;
					nx_phase = PH_SCAN;
				end
			end
			PH_CODE: begin
				do_open = 1'b1;
			end
			PH_LEN_HI: begin
				nx_len   = {data_byte, 8'h00};
				nx_phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				if (len_full <= LEN_SELF) begin
					nx_len    = 16'd0;
					do_finish = 1'b1;
				end else begin
					nx_len   = len_full - LEN_SELF;
					nx_phase = PH_BODY;
				end
			end
			PH_BODY: begin
				nx_len = len_q - 16'd1;
				if (len_q == 16'd1) do_finish = 1'b1;
			end
			PH_SCAN: begin
				// armed prefix plus a real code ends the scanned data
				if (saw_q && data_byte != CODE_STUFF && data_byte != CODE_PREFIX) begin
					va       = 1'b1;
					nx_start = ff_pos;
					nx_saw   = 1'b0;
					do_open  = 1'b1;
				end else begin
					nx_saw = (data_byte == CODE_PREFIX);
				end
			end
			default: begin
				nx_phase = PH_PREFIX;
			end
		endcase

		// marker code byte: classify, or fall into a scan on stuffing/fill
		if (do_open) begin
			if (data_byte == CODE_STUFF || data_byte == CODE_PREFIX) begin
				nx_kind  = sos_q ? K_IMG : K_UNK;
				nx_code  = 8'h00;
				nx_sub   = 8'h00;
				nx_sos   = 1'b0;
				nx_saw   = (data_byte == CODE_PREFIX);
				nx_phase = PH_SCAN;
			end else begin
				nx_sos  = 1'b0;
				nx_code = data_byte;
				nx_kind = cls.kind;
				nx_sub  = cls.sub;
				if (cls.alone) begin
					nx_phase = PH_PREFIX;
					vb       = 1'b1;
				end else begin
					nx_phase = PH_LEN_HI;
				end
			end
		end

		// end of a length segment
		if (do_finish) begin
			if (kind_q == K_SOS) nx_sos = 1'b1;
			nx_phase = PH_PREFIX;
			vb       = 1'b1;
		end

		res_a = make_res(kind_q, sub_q, code_q, start_q, {1'b0, ff_pos}, 1'b0);
		res_b = make_res(nx_kind, nx_sub, nx_code, nx_start, pos_inc, 1'b0);
		res_c = make_res(nx_kind, nx_sub, nx_code, nx_start, pos_inc,
		                 nx_phase != PH_SCAN);

		// end of stream flushes an open segment and restarts at offset zero
		if (end_of_stream) begin
			vc       = (nx_phase != PH_PREFIX);
			nx_phase = PH_PREFIX;
			nx_pos   = '0;
			nx_kind  = K_SOF;
			nx_code  = 8'h00;
			nx_sub   = 8'h00;
			nx_start = '0;
			nx_len   = 16'd0;
			nx_saw   = 1'b0;
			nx_sos   = 1'b0;
		end
	end

	// pack the results in order into two queue slots
	always_comb begin
		n_res = 2'({1'b0, va}) + 2'({1'b0, vb}) + 2'({1'b0, vc});
		if (va) slot0 = res_a;
		else if (vb) slot0 = res_b;
		else slot0 = res_c;
		slot1 = (va && vb) ? res_b : res_c;
		slot0.last = (n_res == 2'd1);
		slot1.last = 1'b1;
		push_cnt = accept ? n_res : 2'd0;
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX;
			pos_q   <= '0;
			kind_q  <= K_SOF;
			code_q  <= 8'h00;
			sub_q   <= 8'h00;
			start_q <= '0;
			len_q   <= 16'd0;
			saw_q   <= 1'b0;
			sos_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= nx_phase;
			pos_q   <= nx_pos;
			kind_q  <= nx_kind;
			code_q  <= nx_code;
			sub_q   <= nx_sub;
			start_q <= nx_start;
			len_q   <= nx_len;
			saw_q   <= nx_saw;
			sos_q   <= nx_sos;
		end
	end

	jms_out_fifo #(
		.DEPTH(OUT_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.push0    (slot0),
		.push1    (slot1),
		.room2    (room2),
		.pop_valid(out_valid),
		.pop_ready(out_ready),
		.pop_data (head)
	);

	assign seg_kind    = head.kind;
	assign seg_sub     = head.sub;
	assign marker_code = head.code;
	assign seg_offset  = head.offset;
	assign seg_size    = head.size;
	assign truncated   = head.trunc;
	assign last_result = head.last;

`ifndef SYNTHESIS
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && truncated) |-> last_result)
		else $error("truncated segment not the final result of its beat");
	a_data_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (seg_kind == K_IMG || seg_kind == K_UNK)) |-> (marker_code == 8'h00))
		else $error("scanned segment carries a marker code");
	a_eos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_stream) |=> (phase_q == PH_PREFIX && pos_q == '0))
		else $error("stream state not restarted after end of stream");
`endif

endmodule

[verif/tb.sv]
// tb: self-checking bench for jpeg_marker_segmenter, byte stream in, segment beats out.
// Depends on jms_pkg for the segment kind type, the result struct and the marker codes.
// A software parser of the stream predicts every segment; beats are compared in order.
module tb;
	import jms_pkg::*;

	// marker codes that the package does not name
	localparam logic [7:0] CODE_DQT = 8'hDB;
	localparam logic [7:0] CODE_DNL = 8'hDC;
	localparam logic [7:0] CODE_DRI = 8'hDD;
	localparam logic [7:0] CODE_DHP = 8'hDE;
	localparam logic [7:0] CODE_COM = 8'hFE;
	localparam int NUM_EDGE_CODES = 23;
	localparam logic [7:0] EDGE_CODES [0:NUM_EDGE_CODES-1] = '{
		CODE_TEM, CODE_RES, CODE_RES_HI, CODE_SOF, CODE_DHT, CODE_JPG0, CODE_DAC,
		CODE_SOF_HI, CODE_RST, CODE_RST_HI, CODE_SOI, CODE_EOI, CODE_SOS, CODE_DQT,
		CODE_DNL, CODE_DRI, CODE_DHP, CODE_EXP, CODE_APP, CODE_APP_HI, CODE_JPG,
		CODE_JPG_HI, CODE_COM
	};
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES = 16;

	typedef enum logic [2:0] {
		PH_PREFIX, PH_CODE, PH_LEN_HI, PH_LEN_LO, PH_BODY, PH_SCAN
	} parse_phase_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        end_of_stream;
	logic        out_valid;
	logic        out_ready;
	logic [4:0]  seg_kind;
	logic [7:0]  seg_sub;
	logic [7:0]  marker_code;
	logic [31:0] seg_offset;
	logic [31:0] seg_size;
	logic        truncated;
	logic        last_result;

	jpeg_marker_segmenter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.seg_kind      (seg_kind),
		.seg_sub       (seg_sub),
		.marker_code   (marker_code),
		.seg_offset    (seg_offset),
		.seg_size      (seg_size),
		.truncated     (truncated),
		.last_result   (last_result)
	);

	// parser state of the prediction
	parse_phase_t parse_ph;
	logic [31:0]  stream_pos;
	seg_kind_t    cur_kind;
	logic [7:0]   cur_code;
	logic [7:0]   cur_sub;
	logic [31:0]  seg_start;
	logic [15:0]  len_left;
	logic         prefix_armed;
	logic         in_image;

	seg_res_t     byte_segs[$];
	seg_res_t     expected_segs[$];
	logic [7:0]   stream_bytes[$];
	int           mismatches = 0;
	int           bytes_sent = 0;
	int           send_idle_pct = 0;
	int           stall_pct = 0;
	int           hold_asks = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// kind and sub-index of a marker code in 0x01..0xFE; returns 1 for standalone markers
	function automatic logic marker_class(input logic [7:0] c, output seg_kind_t k,
			output logic [7:0] s);
		logic alone;
		alone = 1'b0;
		s = 8'h00;
		k = K_COM;
		if (c == CODE_TEM) begin
			k = K_TEM;
			alone = 1'b1;
		end else if (c >= CODE_RES && c <= CODE_RES_HI) begin
			k = K_RES;
			s = c - CODE_RES;
		end else if (c == CODE_DHT) k = K_DHT;
		else if (c == CODE_JPG0) k = K_JPG;
		else if (c == CODE_DAC) k = K_DAC;
		else if (c >= CODE_SOF && c <= CODE_SOF_HI) begin
			k = K_SOF;
			s = c - CODE_SOF;
		end else if (c >= CODE_RST && c <= CODE_RST_HI) begin
			k = K_RST;
			s = c - CODE_RST;
			alone = 1'b1;
		end else if (c == CODE_SOI || c == CODE_EOI) begin
			k = (c == CODE_SOI) ? K_SOI : K_EOI;
			alone = 1'b1;
		end else if (c == CODE_SOS) k = K_SOS;
		else if (c == CODE_DQT) k = K_DQT;
		else if (c == CODE_DNL) k = K_DNL;
		else if (c == CODE_DRI) k = K_DRI;
		else if (c == CODE_DHP) k = K_DHP;
		else if (c == CODE_EXP) k = K_EXP;
		else if (c >= CODE_APP && c <= CODE_APP_HI) begin
			k = K_APP;
			s = c - CODE_APP;
		end else if (c >= CODE_JPG && c <= CODE_JPG_HI) begin
			k = K_JPG;
			s = c - CODE_JPG;
		end
		return alone;
	endfunction

	// parser back to the start of a stream
	task automatic clear_parser();
		parse_ph = PH_PREFIX;
		stream_pos = '0;
		cur_kind = K_SOF;
		cur_code = '0;
		cur_sub = '0;
		seg_start = '0;
		len_left = '0;
		prefix_armed = 1'b0;
		in_image = 1'b0;
	endtask

	// close the open segment at an exclusive end position
	task automatic close_segment(input logic [32:0] end_excl, input logic trunc);
		seg_res_t r;
		logic [32:0] span;
		span = (end_excl >= {1'b0, seg_start}) ? end_excl - {1'b0, seg_start} : 33'd0;
		r.kind = cur_kind;
		r.sub = cur_sub;
		r.code = cur_code;
		r.offset = seg_start;
		r.size = span[32] ? 32'hFFFF_FFFF : span[31:0];
		r.trunc = trunc;
		r.last = 1'b0;
		byte_segs.insert(byte_segs.size(), r);
	endtask

	// data without a marker: image data right after sos, otherwise unknown
	task automatic start_scan(input logic armed);
		cur_kind = in_image ? K_IMG : K_UNK;
		cur_code = '0;
		cur_sub = '0;
		in_image = 1'b0;
		prefix_armed = armed;
		parse_ph = PH_SCAN;
	endtask

	task automatic open_marker(input logic [7:0] c, input logic [31:0] pos);
		seg_kind_t k;
		logic [7:0] s;
		logic alone;
		if (c == CODE_STUFF || c == CODE_PREFIX) begin
			start_scan(c == CODE_PREFIX);
		end else begin
			alone = marker_class(c, k, s);
			in_image = 1'b0;
			cur_code = c;
			cur_kind = k;
			cur_sub = s;
			if (alone) begin
				parse_ph = PH_PREFIX;
				close_segment({1'b0, pos} + 33'd1, 1'b0);
			end else begin
				parse_ph = PH_LEN_HI;
			end
		end
	endtask

	task automatic close_length(input logic [31:0] pos);
		if (cur_kind == K_SOS) in_image = 1'b1;
		parse_ph = PH_PREFIX;
		close_segment({1'b0, pos} + 33'd1, 1'b0);
	endtask

	// advance the parser by one accepted byte and queue the segments it finishes
	task automatic predict_byte(input logic [7:0] d, input logic eos);
		logic [31:0] pos;
		logic [31:0] ff_pos;
		logic [15:0] total;
		seg_res_t r;
		pos = stream_pos;
		byte_segs.delete();
		case (parse_ph)
			PH_PREFIX: begin
				seg_start = pos;
				if (d == CODE_PREFIX) begin
					cur_kind = in_image ? K_IMG : K_UNK;
					cur_code = '0;
					cur_sub = '0;
					parse_ph = PH_CODE;
				end else begin
					start_scan(1'b0);
				end
			end
			PH_CODE: open_marker(d, pos);
			PH_LEN_HI: begin
				len_left = {d, 8'h00};
				parse_ph = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				total = len_left | {8'h00, d};
				if (total <= 16'd2) begin
					len_left = '0;
					close_length(pos);
				end else begin
					len_left = total - 16'd2;
					parse_ph = PH_BODY;
				end
			end
			PH_BODY: begin
				len_left = len_left - 16'd1;
				if (len_left == 16'd0) close_length(pos);
			end
			default: begin
				// a prefix followed by a real code ends the scanned data before the prefix
				if (prefix_armed && d != CODE_STUFF && d != CODE_PREFIX) begin
					ff_pos = (pos != 0) ? pos - 32'd1 : 32'd0;
					close_segment({1'b0, ff_pos}, 1'b0);
					seg_start = ff_pos;
					prefix_armed = 1'b0;
					open_marker(d, pos);
				end else begin
					prefix_armed = (d == CODE_PREFIX);
				end
			end
		endcase
		if (eos) begin
			if (parse_ph != PH_PREFIX)
				close_segment({1'b0, pos} + 33'd1, parse_ph != PH_SCAN);
			clear_parser();
		end else if (pos != 32'hFFFF_FFFF) begin
			stream_pos = pos + 32'd1;
		end
		for (int i = 0; i < byte_segs.size(); i++) begin
			r = byte_segs[i];
			r.last = (i == byte_segs.size() - 1);
			expected_segs.insert(expected_segs.size(), r);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s expected 0x%0h got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// predict on every input beat, then compare every output beat
	always @(posedge clk) begin : seg_monitor
		seg_res_t want;
		if (arst_n) begin
			if (in_valid && in_ready) predict_byte(data_byte, end_of_stream);
			if (out_valid && out_ready) begin
				if (expected_segs.size() == 0) begin
					$error("segment beat with no segment expected (kind %0d offset %0d)",
						seg_kind, seg_offset);
					mismatches++;
				end else begin
					want = expected_segs.pop_front();
					check_field("seg_kind", 32'(want.kind), 32'(seg_kind));
					check_field("seg_sub", 32'(want.sub), 32'(seg_sub));
					check_field("marker_code", 32'(want.code), 32'(marker_code));
					check_field("seg_offset", want.offset, seg_offset);
					check_field("seg_size", want.size, seg_size);
					check_field("truncated", 32'(want.trunc), 32'(truncated));
					check_field("last_result", 32'(want.last), 32'(last_result));
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off whenever one is asked for
	always @(posedge clk) begin : seg_sink
		int hold_seen;
		int hold_left;
		if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// offer one byte, with random idle cycles first, and wait until it is taken
	task automatic send_byte(input logic [7:0] d, input logic eos);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		end_of_stream <= eos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// whole stream, end_of_stream on its final byte
	task automatic send_stream();
		for (int i = 0; i < stream_bytes.size(); i++)
			send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
		bytes_sent += stream_bytes.size();
	endtask

	// one more byte at the end of the stream under construction
	task automatic append_byte(input logic [7:0] d);
		stream_bytes.insert(stream_bytes.size(), d);
	endtask

	task automatic push_random(input int count);
		for (int i = 0; i < count; i++) append_byte(8'($urandom));
	endtask

	// marker code, often one at a range boundary
	function automatic logic [7:0] pick_code();
		if ($urandom_range(99) < 35) return EDGE_CODES[$urandom_range(NUM_EDGE_CODES - 1)];
		return 8'($urandom_range(8'h01, 8'hFE));
	endfunction

	// marker segment with a length field and random body
	task automatic push_length_seg(input logic [7:0] c, input int len);
		append_byte(CODE_PREFIX);
		append_byte(c);
		append_byte(8'(len >> 8));
		append_byte(8'(len));
		if (len > 2) push_random(len - 2);
	endtask

	// jpeg-like file: soi (usually), random marker segments, sos, entropy data with restarts, eoi
	task automatic build_jpeg_stream();
		logic [7:0] c;
		seg_kind_t k;
		logic [7:0] s;
		int n_scan;
		int pick;
		if ($urandom_range(9) != 0) begin
			append_byte(CODE_PREFIX);
			append_byte(CODE_SOI);
		end
		repeat ($urandom_range(4)) begin
			c = pick_code();
			if (marker_class(c, k, s)) begin
				append_byte(CODE_PREFIX);
				append_byte(c);
			end else begin
				push_length_seg(c, $urandom_range(12));
			end
		end
		push_length_seg(CODE_SOS, $urandom_range(2, 8));
		n_scan = $urandom_range(24);
		for (int i = 0; i < n_scan; i++) begin
			c = 8'($urandom);
			if (c != CODE_PREFIX) begin
				append_byte(c);
			end else begin
				pick = $urandom_range(9);
				append_byte(CODE_PREFIX);
				// stuffed byte, fill byte run, or restart marker
				if (pick < 6) begin
					append_byte(CODE_STUFF);
				end else if (pick < 8) begin
					append_byte(CODE_PREFIX);
					append_byte(CODE_STUFF);
				end else begin
					append_byte(8'(CODE_RST + $urandom_range(7)));
				end
			end
		end
		append_byte(CODE_PREFIX);
		append_byte(CODE_EOI);
	endtask

	// short burst rich in prefix bytes
	task automatic build_noise_stream();
		repeat ($urandom_range(1, 20)) begin
			if ($urandom_range(99) < 40) append_byte(CODE_PREFIX);
			else if ($urandom_range(9) == 0) append_byte(CODE_STUFF);
			else append_byte(8'($urandom));
		end
	endtask

	// standalone markers, length segment edges, fill and stuffing, end cases
	task automatic test_directed();
		send_idle_pct = 0;
		stall_pct = 0;
		stream_bytes = '{CODE_PREFIX, CODE_SOI, CODE_PREFIX, CODE_DAC, 8'h00, 8'h02,
			CODE_PREFIX, CODE_TEM, CODE_PREFIX, CODE_RES_HI, 8'h00, 8'h01,
			CODE_PREFIX, CODE_SOS, 8'h00, 8'h03, 8'h7E,
			8'h12, CODE_PREFIX, CODE_STUFF, CODE_PREFIX, CODE_PREFIX, CODE_EOI};
		send_stream();
		// unknown data ended by a marker, then a length segment cut short
		stream_bytes = '{CODE_PREFIX, CODE_STUFF, 8'h7F, CODE_PREFIX, CODE_COM, 8'h00, 8'h04};
		send_stream();
		// prefix as code re-arms; the next byte closes unknown and opens sof
		stream_bytes = '{CODE_PREFIX, CODE_PREFIX, CODE_SOF};
		send_stream();
		// lone prefix at end of stream
		stream_bytes = '{CODE_PREFIX};
		send_stream();
	endtask

	// segment whose length needs the high byte, cut off by the end of the stream
	task automatic test_long_segment();
		stream_bytes.delete();
		append_byte(CODE_PREFIX);
		append_byte(CODE_COM);
		append_byte(8'h01);
		append_byte(8'h04);
		push_random(36);
		send_stream();
	endtask

	// receiver holds off while restart markers keep coming, so the input stalls
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		stream_bytes.delete();
		for (int i = 0; i < 20; i++) begin
			append_byte(CODE_PREFIX);
			append_byte(8'(CODE_RST + (i % 8)));
		end
		hold_asks++;
		send_stream();
	endtask

	// random files and noise, some cut off at a random byte
	task automatic test_random_streams(input int idle, input int stall, input int budget);
		int first;
		int cut;
		first = bytes_sent;
		send_idle_pct = idle;
		stall_pct = stall;
		while (bytes_sent - first < budget) begin
			stream_bytes.delete();
			if ($urandom_range(99) < 70) build_jpeg_stream();
			else build_noise_stream();
			if ($urandom_range(3) == 0) begin
				cut = $urandom_range(1, stream_bytes.size());
				while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
			end
			send_stream();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		data_byte <= '0;
		end_of_stream <= 1'b0;
		clear_parser();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_long_segment();
		test_backpressure();
		test_random_streams(0, 0, 70);
		test_random_streams(67, 0, 70);
		test_random_streams(0, 67, 70);
		test_random_streams(12, 12, 70);
		in_valid <= 1'b0;

		// drain what is still in flight
		while (expected_segs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_segs.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[files.f]
rtl/jms_pkg.sv
rtl/jms_out_fifo.sv
rtl/jpeg_marker_segmenter.sv
verif/tb.sv
